### sv/divisor_count_core_macros.svh
// assertion macros used by the checker file
`ifndef DIVISOR_COUNT_CORE_MACROS_SVH
`define DIVISOR_COUNT_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define DCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define DCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/dcc_pkg.sv
// shared constants and types for the divisor count core
package dcc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int TOTAL_W        = 16;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } dcc_state_t;

endpackage

### sv/divisor_count_core.sv
// divisor count core: trial division over candidates up to the square root
//
// Input channel: in_valid / in_ready with one 32-bit value per beat. Only
// the low WIDTH bits of value are used. Output channel: out_valid /
// out_ready with divisor_total (saturating at 65535) and zero_input.
// A zero value returns divisor_total 0 with zero_input set.
//
// One beat is taken only while the core is idle. Each candidate i from 1
// upward costs one pass of the single restoring divider plus the START
// and WAIT sequencing states, so a nonzero value v takes floor(sqrt(v)) + 1
// divider passes; for WIDTH 32 that is up to 65536 passes. All division
// in the core goes through this one divider.
//
// The finished result sits in an output register; a new value is taken
// while it waits. If the receiver still stalls when the next result is
// ready, the core holds in its final state until the register frees.
// Synchronous reset returns the core to idle and drops out_valid.
module divisor_count_core #(
  parameter int WIDTH = dcc_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dcc_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dcc_pkg::TOTAL_W-1:0]  divisor_total,
  output logic                         zero_input
);
  import dcc_pkg::*;

  dcc_state_t state, state_next;

  logic [WIDTH-1:0]   v;
  logic [WIDTH-1:0]   cand;
  logic [TOTAL_W-1:0] total;
  logic               zero_flag;
  logic [WIDTH-1:0]   v_in;
  logic               div_start;
  logic               div_done;
  logic [WIDTH-1:0]   quo;
  logic [WIDTH-1:0]   rem;
  logic               in_fire;
  logic               out_load;
  logic               past_root;
  logic [TOTAL_W:0]   sum;

  assign v_in      = WIDTH'(value);
  assign in_fire   = in_valid && in_ready;
  assign past_root = cand > quo;
  // a divisor equal to its cofactor counts once
  assign sum       = {1'b0, total} + ((quo == cand) ? (TOTAL_W+1)'(1) : (TOTAL_W+1)'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          state_next = (v_in == '0) ? ST_FINISH : ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_next = past_root ? ST_FINISH : ST_START;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      v         <= v_in;
      cand      <= WIDTH'(1);
      total     <= '0;
      zero_flag <= (v_in == '0);
    end else if (state == ST_WAIT && div_done && !past_root) begin
      cand <= cand + 1'b1;
      if (rem == '0) begin
        total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      divisor_total <= total;
      zero_input    <= zero_flag;
    end
  end

  dcc_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (v),
    .divisor   (cand),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

endmodule

### sv/dcc_div.sv
// restoring divider, one quotient bit per cycle
module dcc_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);
  localparam int CNT_W = $clog2(WIDTH);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   sh;
  logic [WIDTH+1:0] diff;
  logic             borrow;
  logic             last;

  assign sh     = {rem, quo[WIDTH-1]};
  assign diff   = {1'b0, sh} - {2'b00, dvs};
  assign borrow = diff[WIDTH+1];
  assign last   = (cnt == CNT_W'(WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // when the trial subtract borrows, the shifted remainder is below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= borrow ? sh[WIDTH-1:0] : diff[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], ~borrow};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### sv/dcc_chk.sv
// port-level checker for the divisor count core, bound to the top level
`include "divisor_count_core_macros.svh"

module dcc_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [dcc_pkg::VALUE_W-1:0]  value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dcc_pkg::TOTAL_W-1:0]  divisor_total,
  input logic                         zero_input
);
  import dcc_pkg::*;

  logic value_zero;
  assign value_zero = (value == '0);

  // the core works on one value at a time
  `DCC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready && !value_zero, !in_ready, "core ready right after taking a nonzero value")

  `DCC_ASSERT_NOW(a_zero_count, out_valid && zero_input, divisor_total == '0, "zero input with nonzero count")

  `DCC_ASSERT_NOW(a_nonzero_count, out_valid && !zero_input, divisor_total != '0, "nonzero input with zero count")

  `DCC_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(divisor_total) && $stable(zero_input), "result changed while stalled")

endmodule

bind divisor_count_core dcc_chk u_dcc_chk (.*);

### bench/tb_top.sv
// testbench for divisor_count_core: directed and random values checked against a divisor tally
`timescale 1ns / 1ps

module tb_top;
  import dcc_pkg::*;

  localparam int WIDTH = 32;
  // slowest value (all ones) needs 65536 divider passes, the rest far fewer
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [TOTAL_W-1:0] total;
    logic               zero;
  } tally_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [TOTAL_W-1:0] divisor_total;
  logic               zero_input;

  tally_t expected_tallies[$];
  int     error_count = 0;
  int     send_gap_pct = 0;
  int     hold_pct = 0;
  longint cycle_count = 0;

  divisor_count_core #(.WIDTH(WIDTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .divisor_total(divisor_total),
    .zero_input   (zero_input)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_tallies.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // count divisors by trial division up to the square root
  function automatic tally_t predict_tally(logic [VALUE_W-1:0] v);
    tally_t          t;
    longint unsigned x;
    longint unsigned cand;
    longint unsigned count;
    x = v;
    if (WIDTH < 64) x = x & ((64'd1 << WIDTH) - 1);
    count = 0;
    t.value = v;
    if (x == 0) begin
      t.total = '0;
      t.zero = 1'b1;
      return t;
    end
    for (cand = 1; cand <= x / cand; cand++) begin
      if (x % cand == 0) count += (x / cand == cand) ? 1 : 2;
    end
    if (count > TOTAL_MAX) count = TOTAL_MAX;
    t.total = count[TOTAL_W-1:0];
    t.zero = 1'b0;
    return t;
  endfunction

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= hold_pct);
  end

  always @(posedge clk) begin : check_results
    tally_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tallies.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got total %0d zero %0b",
                 $time, divisor_total, zero_input);
        error_count++;
      end else begin
        want = expected_tallies.pop_front();
        if (divisor_total !== want.total) begin
          $display("%0t: divisor_total for %h: expected %0d, got %0d",
                   $time, want.value, want.total, divisor_total);
          error_count++;
        end
        if (zero_input !== want.zero) begin
          $display("%0t: zero_input for %h: expected %0b, got %0b",
                   $time, want.value, want.zero, zero_input);
          error_count++;
        end
      end
    end
  end

  // in_valid stays high from one beat to the next unless a gap is drawn
  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      value <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
    expected_tallies = {expected_tallies, predict_tally(v)};
  endtask

  task automatic test_zero_and_tiny();
    send_value('0);
    send_value('0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd0);
    send_value(32'h0000_0100);
  endtask

  task automatic test_perfect_squares();
    send_value(32'd4);
    send_value(32'd36);
    send_value(32'd64);
    send_value(32'd100);
    send_value(32'd65025);
    send_value(32'd1048576);
  endtask

  task automatic test_primes_and_composites();
    send_value(32'd97);
    send_value(32'd210);
    send_value(32'd65521);
    send_value(32'd720720);
  endtask

  // all ones: sets every upper bit and is the longest trial run
  task automatic test_full_range();
    send_value(32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int count);
    int pick;
    logic [VALUE_W-1:0] v;
    send_gap_pct = gap_pct;
    hold_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      // keep most values small, a large one needs up to 1024 divider passes
      if (pick < 5) v = '0;
      else if (pick < 70) v = $urandom_range(4095);
      else if (pick < 92) v = $urandom_range(65535);
      else v = $urandom_range(1048575);
      send_value(v);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct = 0;
    hold_pct = 0;
    test_zero_and_tiny();
    test_perfect_squares();
    test_primes_and_composites();
    test_full_range();

    test_random_traffic(0, 0, 25);
    test_random_traffic(50, 0, 25);
    test_random_traffic(0, 50, 25);
    test_random_traffic(17, 17, 25);

    @(negedge clk);
    in_valid <= 1'b0;
    hold_pct = 0;
    while (expected_tallies.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (4 * (WIDTH + 2)) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### divisor_count_core.f
+incdir+sv
sv/dcc_pkg.sv
sv/dcc_div.sv
sv/divisor_count_core.sv
sv/dcc_chk.sv
bench/tb_top.sv
